// ===== sv/yc2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// yc2rgb_pkg
// Shared types, register codes and constant tables for the 4:2:2 pair to
// RGB888 converter.
// ----------------------------------------------------------------------------
package yc2rgb_pkg;

  // Mantissa fraction bits used by the power stage
  localparam int MANT_BITS = 30;
  // Largest internal fraction width the root table covers
  localparam int ROOT_MAX  = 24;

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam logic [0:0] REG_COEF_MODE = 1'b0;
  localparam logic [0:0] REG_GAMMA     = 1'b1;
  localparam logic [CFG_DATA_W-1:0] GAMMA_RESET = 16'd4096;

  typedef enum logic {
    MODE_BT601 = 1'b0,
    MODE_BT709 = 1'b1
  } coef_mode_t;

  // One input beat: two luma samples sharing one chroma pair
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_beat_t;

  // One output beat: two RGB888 pixels
  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
  } out_beat_t;

  typedef logic [MANT_BITS:0] root_tbl_t [ROOT_MAX];

  // Integer square root, elaboration use only
  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bv;
    logic [63:0] xv;
    res = '0;
    bv  = 64'h4000_0000_0000_0000;
    xv  = x;
    for (int s = 0; s < 32; s++) begin
      if (bv > xv) bv = bv >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (bv != '0) begin
        if (xv >= res + bv) begin
          xv  = xv - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
    end
    return res;
  endfunction

  // Q30 roots 2^(2^-i), i = 1..ROOT_MAX, each the truncated root of the last
  function automatic root_tbl_t gen_roots();
    root_tbl_t   tbl;
    logic [63:0] c;
    c = 64'd2 << MANT_BITS;
    for (int i = 0; i < ROOT_MAX; i++) begin
      c      = isqrt64(c << MANT_BITS);
      tbl[i] = c[MANT_BITS:0];
    end
    return tbl;
  endfunction

  localparam root_tbl_t ROOT_TBL = gen_roots();

endpackage

// ===== sv/yc2rgb_if.sv =====
// ----------------------------------------------------------------------------
// yc2rgb_if
// Valid/ready channels for the converter: 4:2:2 pair in, RGB pair out.
// ----------------------------------------------------------------------------
interface yc2rgb_in_if;
  import yc2rgb_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface yc2rgb_out_if;
  import yc2rgb_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ycbcr422_to_rgb_pair_converter.sv =====
// Register path: lookup, exponent, setup, iterations, shift, sum, byte, output.
// Throughput: one pixel pair per cycle while the skid is empty; the power step
// runs one exponent bit per stage and the green divider one quotient bit each.
// A two-deep output (register plus skid) takes one more beat when out
// stalls; the whole pipeline then holds and the input waits.
// Reset (rst_n low, synchronous) empties the pipeline, sets BT.601, unit exp.
// ----------------------------------------------------------------------------
// ycbcr422_to_rgb_pair_converter
// Video-range 4:2:2 pair to two RGB888 pixels, BT.601/BT.709, luma power.
// ----------------------------------------------------------------------------
module ycbcr422_to_rgb_pair_converter #(
  parameter int INTERNAL_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  yc2rgb_in_if.sink                      in_pair,
  yc2rgb_out_if.source                   out_rgb,
  input  logic                           cfg_wr_en,
  input  logic [0:0]                     cfg_index,
  input  logic [yc2rgb_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import yc2rgb_pkg::*;

  localparam int F   = INTERNAL_FRAC_BITS;
  localparam int KW  = F;           // Kr, Kb, denominator
  localparam int LW  = F + 4;       // log2 difference
  localparam int DW  = F + 2;       // chroma terms
  localparam int PW  = LW + 17;     // log times exponent
  localparam int TW  = PW - 12;     // power argument
  localparam int IPW = TW - F;      // integer part
  localparam int MW  = KW + 1 + DW; // K times chroma term
  localparam int XW  = 2 * F + 1;   // divider remainder
  localparam int RW  = MANT_BITS + 1;
  localparam int YW  = F + 3;
  localparam int CW  = F + 5;
  localparam int VW  = CW + 9;
  localparam int D   = F + 6;       // pipeline stages before the output

  localparam longint ONE   = longint'(1) << F;
  localparam longint KR601 = (299 * ONE + 500) / 1000;
  localparam longint KB601 = (114 * ONE + 500) / 1000;
  localparam longint KR709 = (2126 * ONE + 5000) / 10000;
  localparam longint KB709 = (722 * ONE + 5000) / 10000;

  localparam logic [KW-1:0] KR601_V  = KW'(KR601);
  localparam logic [KW-1:0] KB601_V  = KW'(KB601);
  localparam logic [KW-1:0] KR709_V  = KW'(KR709);
  localparam logic [KW-1:0] KB709_V  = KW'(KB709);
  localparam logic [KW-1:0] DEN601_V = KW'(ONE - KR601 - KB601);
  localparam logic [KW-1:0] DEN709_V = KW'(ONE - KR709 - KB709);

  localparam logic signed [VW-1:0] V_MAX  = VW'(255) <<< F;
  localparam logic signed [VW-1:0] V_HALF = VW'(1) <<< (F - 1);

  typedef logic signed [LW-1:0] ltab_t [256];
  typedef logic signed [DW-1:0] dtab_t [256];

  // Fixed point log2 with F truncated fraction bits
  function automatic logic [63:0] log2_fix(int unsigned n);
    int          k;
    logic [63:0] m;
    logic [63:0] frac;
    k = 0;
    for (int j = 0; j < 31; j++) begin
      if ((n >> (j + 1)) != 0) k = j + 1;
    end
    m    = 64'(n) << (MANT_BITS - k);
    frac = '0;
    for (int i = 0; i < F; i++) begin
      m    = (m * m) >> MANT_BITS;
      frac = frac << 1;
      if (m >= (64'd2 << MANT_BITS)) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    return (64'(k) << F) | frac;
  endfunction

  // log2(Y-16) - log2(219) for every luma code; black codes unused
  function automatic ltab_t gen_ltab();
    ltab_t  tbl;
    longint ref_l;
    longint a;
    ref_l = longint'(log2_fix(219));
    for (int y = 0; y < 256; y++) begin
      if (y <= 16) begin
        tbl[y] = '0;
      end else begin
        a      = longint'(log2_fix(y - 16)) - ref_l;
        tbl[y] = LW'(a);
      end
    end
    return tbl;
  endfunction

  // floor(2*c*(1-K)) for every chroma code
  function automatic dtab_t gen_dtab(longint kc);
    dtab_t  tbl;
    longint a;
    longint c;
    longint d;
    for (int cc = 0; cc < 256; cc++) begin
      a = longint'(cc - 128) * ONE + 112;
      if (a >= 0) c = a / 224;
      else        c = -((-a + 223) / 224);
      d       = (2 * c * (ONE - kc)) >>> F;
      tbl[cc] = DW'(d);
    end
    return tbl;
  endfunction

  localparam ltab_t LTAB    = gen_ltab();
  localparam dtab_t DR601_T = gen_dtab(KR601);
  localparam dtab_t DB601_T = gen_dtab(KB601);
  localparam dtab_t DR709_T = gen_dtab(KR709);
  localparam dtab_t DB709_T = gen_dtab(KB709);

  // Channel to byte: scale by 255, clamp, round half up
  function automatic logic [7:0] to_byte(logic signed [CW-1:0] ch);
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] rnd;
    v   = (VW'(ch) <<< 8) - VW'(ch);
    rnd = v + V_HALF;
    if (v < 0)          return 8'd0;
    else if (v > V_MAX) return 8'd255;
    else                return rnd[F+7:F];
  endfunction

  // Mantissa to luma: shift by the integer part, zero for black
  function automatic logic [YW-1:0] shift_y(logic [RW-1:0] r,
                                            logic signed [IPW-1:0] ip,
                                            logic z);
    logic signed [IPW+1:0] sh;
    sh = (IPW + 2)'(MANT_BITS - F) - (IPW + 2)'(ip);
    if (z || sh > $signed((IPW + 2)'(RW - 1))) return '0;
    else return YW'(r >> sh[4:0]);
  endfunction

  typedef struct packed {
    logic [RW-1:0]          r_a;
    logic [RW-1:0]          r_b;
    logic [F-1:0]           f_a;
    logic [F-1:0]           f_b;
    logic signed [IPW-1:0]  ip_a;
    logic signed [IPW-1:0]  ip_b;
    logic                   z_a;
    logic                   z_b;
    logic [XW-1:0]          rem;
    logic [F-1:0]           q;
    logic                   neg;
    logic signed [DW-1:0]   dr;
    logic signed [DW-1:0]   db;
  } it_t;

  // ---------------------------------------------------------------- config
  coef_mode_t            mode_r;
  logic [CFG_DATA_W-1:0] gamma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BT601;
      gamma_r <= GAMMA_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_COEF_MODE: mode_r  <= coef_mode_t'(cfg_wr_data[0]);
        REG_GAMMA:     gamma_r <= cfg_wr_data;
      endcase
    end
  end

  logic [KW-1:0] kr_sel, kb_sel, den_sel;

  always_comb begin
    if (mode_r == MODE_BT709) begin
      kr_sel  = KR709_V;
      kb_sel  = KB709_V;
      den_sel = DEN709_V;
    end else begin
      kr_sel  = KR601_V;
      kb_sel  = KB601_V;
      den_sel = DEN601_V;
    end
  end

  // ------------------------------------------------------- flow control
  logic         en;
  logic [D-1:0] pv_r;
  logic         skid_v_r, out_v_r;
  out_beat_t    skid_q_r, out_q_r;

  assign en            = !skid_v_r;
  assign in_pair.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= '0;
    else if (en) pv_r <= {pv_r[D-2:0], in_pair.valid};
  end

  // ------------------------------------------ stage 1: table lookups
  logic signed [LW-1:0] l_a_r, l_b_r;
  logic                 z_a_r, z_b_r;
  logic signed [DW-1:0] dr1_r, db1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      l_a_r <= LTAB[in_pair.data.luma_first];
      l_b_r <= LTAB[in_pair.data.luma_second];
      z_a_r <= (in_pair.data.luma_first <= 8'd16) && (gamma_r != '0);
      z_b_r <= (in_pair.data.luma_second <= 8'd16) && (gamma_r != '0);
      if (mode_r == MODE_BT709) begin
        dr1_r <= DR709_T[in_pair.data.chroma_red];
        db1_r <= DB709_T[in_pair.data.chroma_blue];
      end else begin
        dr1_r <= DR601_T[in_pair.data.chroma_red];
        db1_r <= DB601_T[in_pair.data.chroma_blue];
      end
    end
  end

  // ---------------------------- stage 2: exponent and K products
  logic signed [PW-1:0] lg_a_c, lg_b_c;
  logic signed [MW-1:0] pr_c, pb_c;
  logic signed [TW-1:0] t_a_r, t_b_r;
  logic signed [MW-1:0] pr_r, pb_r;
  logic                 z_a2_r, z_b2_r;
  logic signed [DW-1:0] dr2_r, db2_r;

  always_comb begin
    lg_a_c = l_a_r * $signed({1'b0, gamma_r});
    lg_b_c = l_b_r * $signed({1'b0, gamma_r});
    pr_c   = $signed({1'b0, kr_sel}) * dr1_r;
    pb_c   = $signed({1'b0, kb_sel}) * db1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_a_r  <= TW'(lg_a_c >>> 12);
      t_b_r  <= TW'(lg_b_c >>> 12);
      pr_r   <= pr_c;
      pb_r   <= pb_c;
      z_a2_r <= z_a_r;
      z_b2_r <= z_b_r;
      dr2_r  <= dr1_r;
      db2_r  <= db1_r;
    end
  end

  // ------------------ stage 3: split argument, set up the divider
  it_t                it_r [F+1];
  it_t                it0_c;
  logic signed [MW:0] xs_c;
  logic [MW:0]        mag_c;

  always_comb begin
    xs_c        = -((MW + 1)'(pr_r) + (MW + 1)'(pb_r));
    mag_c       = xs_c[MW] ? (MW + 1)'(-xs_c) : (MW + 1)'(xs_c);
    it0_c.r_a   = RW'(1) << MANT_BITS;
    it0_c.r_b   = RW'(1) << MANT_BITS;
    it0_c.f_a   = t_a_r[F-1:0];
    it0_c.f_b   = t_b_r[F-1:0];
    it0_c.ip_a  = t_a_r[TW-1:F];
    it0_c.ip_b  = t_b_r[TW-1:F];
    it0_c.z_a   = z_a2_r;
    it0_c.z_b   = z_b2_r;
    it0_c.rem   = XW'(mag_c);
    it0_c.q     = '0;
    it0_c.neg   = xs_c[MW];
    it0_c.dr    = dr2_r;
    it0_c.db    = db2_r;
  end

  always_ff @(posedge clk) begin
    if (en) it_r[0] <= it0_c;
  end

  // ---- iteration stages: one exponent root and one quotient bit each
  for (genvar k = 0; k < F; k++) begin : g_iter
    localparam int J = F - 1 - k;
    it_t             nx_c;
    logic [XW-1:0]   dsh_c;
    logic [2*RW-1:0] pa_c, pb_m_c;

    always_comb begin
      nx_c   = it_r[k];
      dsh_c  = XW'(den_sel) << J;
      pa_c   = (2 * RW)'(it_r[k].r_a) * (2 * RW)'(ROOT_TBL[k]);
      pb_m_c = (2 * RW)'(it_r[k].r_b) * (2 * RW)'(ROOT_TBL[k]);
      if (it_r[k].rem >= dsh_c) begin
        nx_c.rem  = it_r[k].rem - dsh_c;
        nx_c.q[J] = 1'b1;
      end
      if (it_r[k].f_a[J]) nx_c.r_a = pa_c[RW+MANT_BITS-1:MANT_BITS];
      if (it_r[k].f_b[J]) nx_c.r_b = pb_m_c[RW+MANT_BITS-1:MANT_BITS];
    end

    always_ff @(posedge clk) begin
      if (en) it_r[k+1] <= nx_c;
    end
  end

  // ---------------------- shift stage: luma value and green term
  logic [YW-1:0]        y_a_r, y_b_r;
  logic signed [DW-1:0] gq_r, dr_s_r, db_s_r;
  logic [F:0]           qp_c;

  assign qp_c = {1'b0, it_r[F].q} + (F + 1)'(it_r[F].rem != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      y_a_r  <= shift_y(it_r[F].r_a, it_r[F].ip_a, it_r[F].z_a);
      y_b_r  <= shift_y(it_r[F].r_b, it_r[F].ip_b, it_r[F].z_b);
      gq_r   <= it_r[F].neg ? -DW'(qp_c) : DW'(it_r[F].q);
      dr_s_r <= it_r[F].dr;
      db_s_r <= it_r[F].db;
    end
  end

  // ------------------------------------------- sum stage: channels
  logic signed [CW-1:0] r_a_r, g_a_r, b_a_r, r_b_r, g_b_r, b_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r_a_r <= $signed(CW'(y_a_r)) + CW'(dr_s_r);
      g_a_r <= $signed(CW'(y_a_r)) + CW'(gq_r);
      b_a_r <= $signed(CW'(y_a_r)) + CW'(db_s_r);
      r_b_r <= $signed(CW'(y_b_r)) + CW'(dr_s_r);
      g_b_r <= $signed(CW'(y_b_r)) + CW'(gq_r);
      b_b_r <= $signed(CW'(y_b_r)) + CW'(db_s_r);
    end
  end

  // -------------------------------------- byte stage: clamp, round
  out_beat_t px_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r.red_first    <= to_byte(r_a_r);
      px_r.green_first  <= to_byte(g_a_r);
      px_r.blue_first   <= to_byte(b_a_r);
      px_r.red_second   <= to_byte(r_b_r);
      px_r.green_second <= to_byte(g_b_r);
      px_r.blue_second  <= to_byte(b_b_r);
    end
  end

  // ----------------------------------- output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_rgb.ready) begin
      if (pv_r[D-1] && en) skid_v_r <= 1'b1;
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= pv_r[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_rgb.ready) begin
      if (pv_r[D-1] && en) skid_q_r <= px_r;
    end else if (skid_v_r) begin
      out_q_r <= skid_q_r;
    end else begin
      out_q_r <= px_r;
    end
  end

  assign out_rgb.valid = out_v_r;
  assign out_rgb.data  = out_q_r;

endmodule

// ===== sv/yc2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// yc2rgb_checker
// Port-level checks on the converter's handshakes and reset.
// ----------------------------------------------------------------------------
module yc2rgb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A waiting result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out beat withdrawn while stalled");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // Nothing is held back when the output is empty
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Taking a beat always frees room for the next input
  a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready)
    else $error("input blocked after output beat taken");

endmodule

bind ycbcr422_to_rgb_pair_converter yc2rgb_checker u_yc2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pair.ready),
  .out_valid (out_rgb.valid),
  .out_ready (out_rgb.ready)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4:2:2 pair to RGB888 converter. Beats are
// predicted bit-exactly in fixed point and compared field by field. The bench
// runs several BT.601/BT.709 and exponent settings under varied idling and
// a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import yc2rgb_pkg::*;

  localparam int FRAC   = 16;
  localparam int MANT   = 30;
  localparam int LAT    = FRAC + 6;
  localparam int NPHASE = 8;

  // Expected-pixel store and fixed-point colour predictor
  class rgb_scoreboard;
    out_beat_t  pending[$];
    coef_mode_t mode;
    int         gamma;
    int         errors;
    int         checked;

    function new();
      mode  = MODE_BT601;
      gamma = int'(GAMMA_RESET);
    endfunction

    static function longint fdiv(longint a, longint b);
      if (a >= 0) return a / b;
      return -((-a + b - 1) / b);
    endfunction

    static function longint unsigned int_root(longint unsigned x);
      longint unsigned res, bv;
      res = 0;
      bv  = 64'd1 << 62;
      while (bv > x) bv = bv >> 2;
      while (bv != 0) begin
        if (x >= res + bv) begin
          x   = x - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      return res;
    endfunction

    static function longint log2q(int n);
      int              k;
      longint unsigned m, frac;
      k    = 0;
      frac = 0;
      while ((n >> (k + 1)) != 0) k++;
      m = longint'(n) << (MANT - k);
      for (int i = 0; i < FRAC; i++) begin
        m    = (m * m) >> MANT;
        frac = frac << 1;
        if (m >= (64'd2 << MANT)) begin
          frac = frac | 1;
          m    = m >> 1;
        end
      end
      return (longint'(k) << FRAC) | longint'(frac);
    endfunction

    static function longint exp2q(longint t);
      longint          one, ip;
      longint unsigned f, r, c;
      one = longint'(1) << FRAC;
      ip  = fdiv(t, one);
      f   = t - ip * one;
      r   = 64'd1 << MANT;
      c   = 64'd2 << MANT;
      for (int i = 1; i <= FRAC; i++) begin
        c = int_root(c << MANT);
        if ((f >> (FRAC - i)) & 1) r = (r * c) >> MANT;
      end
      if (ip >= 0) begin
        if (ip > 30) ip = 30;
        r = r << ip;
      end else if (-ip >= 62) begin
        r = 0;
      end else begin
        r = r >> (-ip);
      end
      return longint'(r >> (MANT - FRAC));
    endfunction

    function longint luma_power(logic [7:0] y);
      longint l;
      if (y <= 16) return (gamma == 0) ? (longint'(1) << FRAC) : 0;
      l = log2q(int'(y) - 16) - log2q(219);
      return exp2q(fdiv(l * gamma, 4096));
    endfunction

    static function logic [7:0] to_byte(longint ch);
      longint v;
      v = ch * 255;
      if (v < 0) return 8'd0;
      if (v > (longint'(255) << FRAC)) return 8'd255;
      return 8'((v + (longint'(1) << (FRAC - 1))) >>> FRAC);
    endfunction

    function out_beat_t predict_pixels(in_beat_t b);
      longint    one, kr, kb, cb, cr, dr, db, den, y, r, bl, g;
      logic [7:0] ly[2];
      logic [7:0] px[6];
      out_beat_t o;
      one = longint'(1) << FRAC;
      if (mode == MODE_BT709) begin
        kr = (2126 * one + 5000) / 10000;
        kb = (722 * one + 5000) / 10000;
      end else begin
        kr = (299 * one + 500) / 1000;
        kb = (114 * one + 500) / 1000;
      end
      ly[0] = b.luma_first;
      ly[1] = b.luma_second;
      cb  = fdiv((longint'(b.chroma_blue) - 128) * one + 112, 224);
      cr  = fdiv((longint'(b.chroma_red) - 128) * one + 112, 224);
      dr  = fdiv(2 * cr * (one - kr), one);
      db  = fdiv(2 * cb * (one - kb), one);
      den = one - kr - kb;
      for (int p = 0; p < 2; p++) begin
        y  = luma_power(ly[p]);
        r  = y + dr;
        bl = y + db;
        g  = fdiv(y * one - kr * r - kb * bl, den);
        px[p*3]   = to_byte(r);
        px[p*3+1] = to_byte(g);
        px[p*3+2] = to_byte(bl);
      end
      o = {px[0], px[1], px[2], px[3], px[4], px[5]};
      return o;
    endfunction

    function void note_pair(in_beat_t b);
      pending.push_back(predict_pixels(b));
    endfunction

    function void cmp(string name, logic [7:0] e, logic [7:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_pixels(out_beat_t a);
      out_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected output beat %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      cmp("red_first",    e.red_first,    a.red_first);
      cmp("green_first",  e.green_first,  a.green_first);
      cmp("blue_first",   e.blue_first,   a.blue_first);
      cmp("red_second",   e.red_second,   a.red_second);
      cmp("green_second", e.green_second, a.green_second);
      cmp("blue_second",  e.blue_second,  a.blue_second);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [0:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  yc2rgb_in_if  in_pair();
  yc2rgb_out_if out_rgb();

  ycbcr422_to_rgb_pair_converter uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pair     (in_pair),
    .out_rgb     (out_rgb),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  rgb_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;
  int hold_done      = 0;
  int hold_left      = 0;
  int sent           = 0;

  // Clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_rgb.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      out_rgb.ready <= 1'b0;
      hold_left <= 400;
      hold_done <= hold_done + 1;
    end else begin
      out_rgb.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Beat monitors
  always @(posedge clk) begin
    if (rst_n && in_pair.valid && in_pair.ready) sb.note_pair(in_pair.data);
    if (rst_n && out_rgb.valid && out_rgb.ready) sb.check_pixels(out_rgb.data);
  end

  task automatic send_pair(in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_pair.valid <= 1'b0;
      @(posedge clk);
    end
    in_pair.valid <= 1'b1;
    in_pair.data  <= b;
    do @(posedge clk); while (!in_pair.ready);
    sent++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
    if (idx == REG_COEF_MODE) sb.mode = coef_mode_t'(val[0]);
    else sb.gamma = int'(val);
  endtask

  task automatic drain();
    in_pair.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT + 8) @(posedge clk);
  endtask

  function automatic in_beat_t rand_pair();
    in_beat_t b;
    if ($urandom_range(99) < 80) begin
      // mostly video-range samples
      b.luma_first  = 8'($urandom_range(235, 16));
      b.chroma_blue = 8'($urandom_range(240, 16));
      b.luma_second = 8'($urandom_range(235, 16));
      b.chroma_red  = 8'($urandom_range(240, 16));
    end else begin
      b = in_beat_t'($urandom());
    end
    return b;
  endfunction

  // Directed corners: black, white, over/under range, chroma extremes
  task automatic directed_pairs();
    send_pair({8'd16,  8'd128, 8'd235, 8'd128});
    send_pair({8'd0,   8'd0,   8'd255, 8'd255});
    send_pair({8'd255, 8'd255, 8'd0,   8'd0});
    send_pair({8'd15,  8'd16,  8'd17,  8'd240});
    send_pair({8'd235, 8'd240, 8'd236, 8'd16});
    send_pair({8'd128, 8'd0,   8'd64,  8'd255});
    send_pair({8'd16,  8'd240, 8'd16,  8'd240});
    send_pair({8'd126, 8'd127, 8'd129, 8'd128});
    send_pair({8'd170, 8'd85,  8'd85,  8'd170});
    send_pair({8'd1,   8'd129, 8'd254, 8'd127});
  endtask

  initial begin
    int gammas[NPHASE];
    in_pair.valid <= 1'b0;
    in_pair.data  <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= REG_COEF_MODE;
    cfg_wr_data   <= '0;
    rst_n         <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, then BT.709 with zero exponent (every luma maps to one)
    directed_pairs();
    drain();
    write_reg(REG_COEF_MODE, 16'hFFFF);
    write_reg(REG_GAMMA, 16'd0);
    directed_pairs();
    drain();

    gammas = '{4096, 65535, 9011, 1, 2048, 0, 16'($urandom()), 16'($urandom())};
    for (int ph = 0; ph < NPHASE; ph++) begin
      write_reg(REG_COEF_MODE, CFG_DATA_W'({$urandom_range(32767), ph[0]}));
      write_reg(REG_GAMMA, 16'(gammas[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (ph == 0) hold_reqs++;
      for (int i = 0; i < 178; i++) send_pair(rand_pair());
      drain();
    end

    $display("Converted %0d pixel pairs over %0d register settings, both modes,",
             sb.checked, NPHASE + 2);
    $display("exponents 0 to 65535, varied idling and a long output hold-off.");
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Timeout
  initial begin
    #(12 * 600000);
    $display("Verification failed");
    $finish;
  end
endmodule
